[rtl/prescaled_countdown_timer_assert.svh]
// Assertion macros for the prescaled countdown timer.
// Included by the top level; relies on clk_i and rst_ni in the including scope.
`ifndef PRESCALED_COUNTDOWN_TIMER_ASSERT_SVH
`define PRESCALED_COUNTDOWN_TIMER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("timer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("timer assertion failed");

`endif

[rtl/pct_pkg.sv]
// Shared constants, codes and types for the prescaled countdown timer.
// No dependencies; imported by every module of the block.
package pct_pkg;

  localparam int unsigned CountWidth    = 16;
  localparam int unsigned PrescaleWidth = 8;
  localparam int unsigned DivSelWidth   = 3;
  localparam int unsigned DivWidth      = 5;
  localparam int unsigned ReqWidth      = 2;
  localparam int unsigned CfgIdxWidth   = 2;
  localparam int unsigned CfgDataWidth  =
    (CountWidth > PrescaleWidth) ? CountWidth : PrescaleWidth;

  localparam logic [ReqWidth-1:0] ReqTick = 2'd0;
  localparam logic [ReqWidth-1:0] ReqCtrl = 2'd1;
  localparam logic [ReqWidth-1:0] ReqRead = 2'd2;

  localparam logic [CfgIdxWidth-1:0] CfgPrescale = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgDivider  = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgBuffer   = 2'd2;

  localparam logic [DivSelWidth-1:0] DivSelMax = 3'd4;

  typedef struct packed {
    logic [CountWidth-1:0] count;
    logic                  expired;
    logic                  running;
  } result_t;

endpackage

[rtl/prescaled_countdown_timer.sv]
// Prescaled countdown timer channel: one beat in and one result beat out per
// clock cycle while neither side stalls. Each beat is a source tick, a control
// write or a count read; its result comes from the state update logic and is
// held by the two-entry output buffer, in the output register or, while the
// output is stalled, in the skid register; once the skid is full, in_stall_o
// rises until the output drains. Configuration writes are registered first.
// Depends on pct_pkg, pct_core, pct_out_buf and the assertion macro header.
`include "prescaled_countdown_timer_assert.svh"

module prescaled_countdown_timer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pct_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [pct_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [pct_pkg::ReqWidth-1:0]     req_type_i,
  input  logic                             ctrl_start_i,
  input  logic                             ctrl_manual_update_i,
  input  logic                             ctrl_auto_reload_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [pct_pkg::CountWidth-1:0]   count_observed_o,
  output logic                             expired_o,
  output logic                             is_running_o
);
  import pct_pkg::*;

  logic    beat;
  logic    buf_full;
  result_t core_result;
  result_t out_result;

  assign in_stall_o = buf_full;
  assign beat       = in_valid_i && !buf_full;

  pct_core u_core (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .beat_i               (beat),
    .req_type_i           (req_type_i),
    .ctrl_start_i         (ctrl_start_i),
    .ctrl_manual_update_i (ctrl_manual_update_i),
    .ctrl_auto_reload_i   (ctrl_auto_reload_i),
    .result_o             (core_result)
  );

  pct_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (beat),
    .data_i      (core_result),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .data_o      (out_result)
  );

  assign count_observed_o = out_result.count;
  assign expired_o        = out_result.expired;
  assign is_running_o     = out_result.running;

  `PCT_ASSERT_SAME(a_expired_at_zero, out_valid_o && expired_o, count_observed_o == '0)
  `PCT_ASSERT_NEXT(a_accept_gives_result, in_valid_i && !in_stall_o, out_valid_o)
  `PCT_ASSERT_SAME(a_skid_fills_on_stall, $rose(in_stall_o), $past(out_valid_o && out_stall_i))

endmodule

[rtl/pct_core.sv]
// Timer state: configuration registers, prescaler, divider and down-counter.
// Depends on pct_pkg; produces one result per accepted beat.
module pct_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pct_pkg::CfgIdxWidth-1:0]      cfg_idx_i,
  input  logic [pct_pkg::CfgDataWidth-1:0]     cfg_data_i,
  input  logic                                 beat_i,
  input  logic [pct_pkg::ReqWidth-1:0]         req_type_i,
  input  logic                                 ctrl_start_i,
  input  logic                                 ctrl_manual_update_i,
  input  logic                                 ctrl_auto_reload_i,
  output pct_pkg::result_t                     result_o
);
  import pct_pkg::*;

  logic [PrescaleWidth-1:0] prescale_q;
  logic [DivSelWidth-1:0]   div_sel_q;
  logic [CountWidth-1:0]    buffer_q;

  logic [PrescaleWidth-1:0] pre_cnt_q, pre_cnt_d;
  logic [DivWidth-1:0]      div_cnt_q, div_cnt_d;
  logic [CountWidth-1:0]    down_q, down_d;
  logic                     run_q, run_d;
  logic                     reload_q, reload_d;
  logic                     expired_d;

  logic                     pre_fire;
  logic                     div_fire;
  logic [DivSelWidth-1:0]   sel_c;
  logic [DivWidth-1:0]      div_mask;
  logic [CountWidth-1:0]    down_dec;

  always_comb begin
    pre_fire = (pre_cnt_q >= prescale_q);
    sel_c    = (div_sel_q > DivSelMax) ? DivSelMax : div_sel_q;
    div_mask = DivWidth'(({{DivWidth{1'b0}}, 1'b1} << (sel_c + 3'd1)) - 1'b1);
    div_fire = ((div_cnt_q & div_mask) == div_mask);
    down_dec = down_q - 1'b1;

    pre_cnt_d = pre_cnt_q;
    div_cnt_d = div_cnt_q;
    down_d    = down_q;
    run_d     = run_q;
    reload_d  = reload_q;
    expired_d = 1'b0;

    case (req_type_i)
      ReqTick: begin
        if (pre_fire) begin
          pre_cnt_d = '0;
          div_cnt_d = div_cnt_q + 1'b1;
          if (div_fire && run_q) begin
            if (down_q == '0) begin
              if (reload_q) begin
                down_d = buffer_q;
              end else begin
                run_d = 1'b0;
              end
            end else begin
              down_d = down_dec;
              if (down_dec == '0) begin
                expired_d = 1'b1;
                if (!reload_q) begin
                  run_d = 1'b0;
                end
              end
            end
          end
        end else begin
          pre_cnt_d = pre_cnt_q + 1'b1;
        end
      end
      ReqCtrl: begin
        if (ctrl_manual_update_i) begin
          down_d = buffer_q;
        end
        run_d    = ctrl_start_i;
        reload_d = ctrl_auto_reload_i;
      end
      default: begin
        // Count reads leave the state untouched.
      end
    endcase

    result_o.count   = down_d;
    result_o.expired = expired_d;
    result_o.running = run_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
      div_sel_q  <= '0;
      buffer_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPrescale: prescale_q <= cfg_data_i[PrescaleWidth-1:0];
        CfgDivider:  div_sel_q  <= cfg_data_i[DivSelWidth-1:0];
        CfgBuffer:   buffer_q   <= cfg_data_i[CountWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_cnt_q <= '0;
      div_cnt_q <= '0;
      down_q    <= '0;
      run_q     <= 1'b0;
      reload_q  <= 1'b0;
    end else if (beat_i) begin
      pre_cnt_q <= pre_cnt_d;
      div_cnt_q <= div_cnt_d;
      down_q    <= down_d;
      run_q     <= run_d;
      reload_q  <= reload_d;
    end
  end

endmodule

[rtl/pct_out_buf.sv]
// Two-entry result buffer: an output register backed by a skid register.
// Depends on pct_pkg for the result type.
module pct_out_buf (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pct_pkg::result_t data_i,
  output logic             full_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pct_pkg::result_t data_o
);
  import pct_pkg::*;

  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign data_o      = out_q;

endmodule
